### src/ppzc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppzc_pkg - shared types and constants of the polygon zone classifier
// Microcode labels, control/status structs and the control store itself.
// ---------------------------------------------------------------------------
package ppzc_pkg;

	localparam int ZONE_COUNT     = 3;
	localparam int MAX_VERTICES   = 16;
	localparam int MIN_POLY_VERTS = 3;
	localparam int STORE_DEPTH    = ZONE_COUNT * MAX_VERTICES;

	localparam int ZONE_W     = 2;
	localparam int SLOT_W     = 4;
	localparam int CNT_W      = 5;
	localparam int ADDR_W     = $clog2(STORE_DEPTH);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_COUNT_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_SECOND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_THIRD  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FALLBACK     = 2'd3;

	localparam logic [ZONE_W-1:0] FALLBACK_RESET = 2'd1;

	// microprogram labels
	typedef enum logic [3:0] {
		U_IDLE,
		U_ZINIT,
		U_RDJ,
		U_MUL1,
		U_MUL2,
		U_TEST,
		U_ZDONE,
		U_ZNEXT,
		U_HIT,
		U_MISS
	} upc_t;

	// vertex memory read address source
	typedef enum logic [1:0] {
		RA_NONE,
		RA_LAST,
		RA_IDX,
		RA_NEXT
	} rsel_t;

	// branch condition
	typedef enum logic [2:0] {
		C_ALWAYS,
		C_QSTART,
		C_SHORT,
		C_EDGE_LAST,
		C_INSIDE,
		C_LAST_ZONE
	} cond_t;

	typedef struct packed {
		logic  accept;
		logic  zone_setup;
		logic  ld_prev;
		logic  mul1;
		logic  mul2;
		logic  test;
		logic  zone_inc;
		logic  emit_hit;
		logic  emit_miss;
		rsel_t rd_sel;
		cond_t cond;
		upc_t  tgt_t;
		upc_t  tgt_f;
	} ucode_t;

	// sequencer -> datapath
	typedef struct packed {
		logic  wr_en;
		logic  ld_point;
		logic  zone_setup;
		logic  ld_prev;
		logic  mul1;
		logic  mul2;
		logic  test;
		logic  zone_inc;
		rsel_t rd_sel;
	} ctl_t;

	// datapath -> sequencer
	typedef struct packed {
		logic              short_poly;
		logic              edge_last;
		logic              in_poly;
		logic              last_zone;
		logic [ZONE_W-1:0] zone;
	} stat_t;

	function automatic logic [CNT_W-1:0] cnt_clamp(input logic [CNT_W-1:0] n);
		logic [CNT_W-1:0] r;
		r = (n > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : n;
		return r;
	endfunction

	// control store: one word per step
	function automatic ucode_t ucode_rom(input upc_t pc);
		ucode_t uc;
		uc = '0;
		case (pc)
			U_IDLE: begin
				uc.accept = 1'b1;
				uc.cond   = C_QSTART;
				uc.tgt_t  = U_ZINIT;
				uc.tgt_f  = U_IDLE;
			end
			U_ZINIT: begin
				uc.zone_setup = 1'b1;
				uc.rd_sel     = RA_LAST;
				uc.cond       = C_SHORT;
				uc.tgt_t      = U_ZDONE;
				uc.tgt_f      = U_RDJ;
			end
			U_RDJ: begin
				uc.ld_prev = 1'b1;
				uc.rd_sel  = RA_IDX;
				uc.cond    = C_ALWAYS;
				uc.tgt_t   = U_MUL1;
				uc.tgt_f   = U_MUL1;
			end
			U_MUL1: begin
				uc.mul1  = 1'b1;
				uc.cond  = C_ALWAYS;
				uc.tgt_t = U_MUL2;
				uc.tgt_f = U_MUL2;
			end
			U_MUL2: begin
				uc.mul2  = 1'b1;
				uc.cond  = C_ALWAYS;
				uc.tgt_t = U_TEST;
				uc.tgt_f = U_TEST;
			end
			U_TEST: begin
				uc.test   = 1'b1;
				uc.rd_sel = RA_NEXT;
				uc.cond   = C_EDGE_LAST;
				uc.tgt_t  = U_ZDONE;
				uc.tgt_f  = U_MUL1;
			end
			U_ZDONE: begin
				uc.cond  = C_INSIDE;
				uc.tgt_t = U_HIT;
				uc.tgt_f = U_ZNEXT;
			end
			U_ZNEXT: begin
				uc.zone_inc = 1'b1;
				uc.cond     = C_LAST_ZONE;
				uc.tgt_t    = U_MISS;
				uc.tgt_f    = U_ZINIT;
			end
			U_HIT: begin
				uc.emit_hit = 1'b1;
				uc.cond     = C_ALWAYS;
				uc.tgt_t    = U_IDLE;
				uc.tgt_f    = U_IDLE;
			end
			U_MISS: begin
				uc.emit_miss = 1'b1;
				uc.cond      = C_ALWAYS;
				uc.tgt_t     = U_IDLE;
				uc.tgt_f     = U_IDLE;
			end
			default: begin
				uc.cond  = C_ALWAYS;
				uc.tgt_t = U_IDLE;
				uc.tgt_f = U_IDLE;
			end
		endcase
		return uc;
	endfunction

endpackage

### src/ppzc_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppzc_datapath - vertex memory and edge-crossing datapath
// One shared multiplier; the microcode sequences reads, products and tests.
// ---------------------------------------------------------------------------
module ppzc_datapath #(
	parameter int COORD_WIDTH = 20
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  ppzc_pkg::ctl_t                                    ctl,
	input  logic [ppzc_pkg::ZONE_W-1:0]                       wr_zone,
	input  logic [ppzc_pkg::SLOT_W-1:0]                       wr_slot,
	input  logic signed [COORD_WIDTH-1:0]                     in_x,
	input  logic signed [COORD_WIDTH-1:0]                     in_y,
	input  logic [ppzc_pkg::ZONE_COUNT-1:0][ppzc_pkg::CNT_W-1:0] counts,
	output ppzc_pkg::stat_t                                   stat
);
	import ppzc_pkg::*;

	localparam int DW = COORD_WIDTH + 1;
	localparam int PW = 2 * DW;

	logic [2*COORD_WIDTH-1:0] mem [STORE_DEPTH];
	logic [2*COORD_WIDTH-1:0] rd_q;

	logic [ZONE_W-1:0] zone_q;
	logic [CNT_W-1:0]  n_q;
	logic [SLOT_W-1:0] idx_q;
	logic              inside_q;

	logic signed [COORD_WIDTH-1:0] px_q, py_q, xi_q, yi_q, xj_q, yj_q;
	logic signed [PW-1:0]          lhs_q, rhs_q;

	logic [CNT_W-1:0]  n_cur;
	logic [SLOT_W-1:0] last_slot;
	logic [ADDR_W-1:0] base, rd_addr, wr_addr;
	logic              rd_en, edge_last, last_zone;

	logic signed [COORD_WIDTH-1:0] rd_x, rd_y;
	logic signed [DW-1:0]          dxa, dya, dxb, dyb, mul_a, mul_b;
	logic signed [PW-1:0]          prod;
	logic                          straddle, up, hit;

	assign n_cur     = cnt_clamp(counts[zone_q]);
	assign last_slot = (n_cur == '0) ? '0 : SLOT_W'(n_cur - CNT_W'(1));
	assign base      = ADDR_W'(zone_q) * ADDR_W'(MAX_VERTICES);
	assign wr_addr   = ADDR_W'(wr_zone) * ADDR_W'(MAX_VERTICES) + ADDR_W'(wr_slot);
	assign edge_last = (CNT_W'(idx_q) + CNT_W'(1)) == n_q;
	assign last_zone = zone_q == ZONE_W'(ZONE_COUNT - 1);

	always_comb begin
		case (ctl.rd_sel)
			RA_LAST: rd_addr = base + ADDR_W'(last_slot);
			RA_IDX:  rd_addr = base + ADDR_W'(idx_q);
			RA_NEXT: rd_addr = base + ADDR_W'(idx_q) + ADDR_W'(1);
			default: rd_addr = base;
		endcase
	end

	// no read past the last vertex of the zone
	assign rd_en = (ctl.rd_sel != RA_NONE) && !((ctl.rd_sel == RA_NEXT) && edge_last);

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= {in_y, in_x};
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_x = rd_q[COORD_WIDTH-1:0];
	assign rd_y = rd_q[2*COORD_WIDTH-1:COORD_WIDTH];

	// lhs = (px - xi) * (yj - yi), rhs = (xj - xi) * (py - yi)
	assign dxa   = DW'(px_q) - DW'(rd_x);
	assign dya   = DW'(yj_q) - DW'(rd_y);
	assign dxb   = DW'(xj_q) - DW'(xi_q);
	assign dyb   = DW'(py_q) - DW'(yi_q);
	assign mul_a = ctl.mul1 ? dxa : dxb;
	assign mul_b = ctl.mul1 ? dya : dyb;
	assign prod  = mul_a * mul_b;

	assign straddle = (yi_q > py_q) != (yj_q > py_q);
	assign up       = yj_q > yi_q;
	assign hit      = up ? (lhs_q < rhs_q) : (rhs_q < lhs_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q   <= '0;
			n_q      <= '0;
			idx_q    <= '0;
			inside_q <= 1'b0;
		end else begin
			if (ctl.ld_point) begin
				zone_q <= '0;
			end else if (ctl.zone_inc && !last_zone) begin
				zone_q <= zone_q + ZONE_W'(1);
			end
			if (ctl.zone_setup) begin
				n_q      <= n_cur;
				idx_q    <= '0;
				inside_q <= 1'b0;
			end else if (ctl.test) begin
				idx_q <= idx_q + SLOT_W'(1);
				if (straddle && hit) begin
					inside_q <= !inside_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_point) begin
			px_q <= in_x;
			py_q <= in_y;
		end
		if (ctl.ld_prev) begin
			xj_q <= rd_x;
			yj_q <= rd_y;
		end else if (ctl.test) begin
			xj_q <= xi_q;
			yj_q <= yi_q;
		end
		if (ctl.mul1) begin
			xi_q  <= rd_x;
			yi_q  <= rd_y;
			lhs_q <= prod;
		end
		if (ctl.mul2) begin
			rhs_q <= prod;
		end
	end

	assign stat.short_poly = n_cur < CNT_W'(MIN_POLY_VERTS);
	assign stat.edge_last  = edge_last;
	assign stat.in_poly    = inside_q;
	assign stat.last_zone  = last_zone;
	assign stat.zone       = zone_q;

	a_test_full_poly: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.test |-> (n_q >= CNT_W'(MIN_POLY_VERTS)))
		else $error("edge test on a polygon with too few vertices");

	a_edge_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.mul1 |-> (CNT_W'(idx_q) < n_q))
		else $error("edge index past vertex count");

	a_zone_range: assert property (@(posedge clk) disable iff (!arst_n)
		zone_q < ZONE_W'(ZONE_COUNT))
		else $error("zone index past the last zone");

endmodule

### src/priority_polygon_zone_classifier.sv
`timescale 1ns / 1ps
// Query: each zone scanned runs U_ZINIT, U_RDJ, the edge loop per vertex, U_ZDONE and,
//   on no match, U_ZNEXT (a zone with fewer than three vertices skips U_RDJ and the
//   loop), then U_HIT or U_MISS. One item at a time; busy is high from the cycle after
//   a query is taken until its result; per edge: memory read, two shared products, test.
// Result: done pulses for one cycle with zone_code/matched; the receiver cannot stall.
// Reset: arst_n clears counts to 0 and fallback to zone 1; vertex memory is not cleared.
// ---------------------------------------------------------------------------
// priority_polygon_zone_classifier - priority point-in-polygon zone lookup
// Microcoded sequencer scanning three vertex tables with even-odd ray casting.
// ---------------------------------------------------------------------------
module priority_polygon_zone_classifier #(
	parameter int COORD_WIDTH = 20
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// command transaction
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 operation,
	input  logic [ppzc_pkg::ZONE_W-1:0]          zone_select,
	input  logic [ppzc_pkg::SLOT_W-1:0]          vertex_slot,
	input  logic signed [COORD_WIDTH-1:0]        coord_x,
	input  logic signed [COORD_WIDTH-1:0]        coord_y,
	// result
	output logic                                 done,
	output logic [ppzc_pkg::ZONE_W-1:0]          zone_code,
	output logic                                 matched,
	// configuration write transaction
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ppzc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ppzc_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import ppzc_pkg::*;

	// configuration registers
	logic [ZONE_COUNT-1:0][CNT_W-1:0] cnt_q;
	logic [ZONE_W-1:0]                fb_q;
	logic [ZONE_W-1:0]                fb_eff;

	// sequencer
	upc_t   upc_q, upc_d;
	ucode_t uc;
	logic   take, accept;
	ctl_t   ctl;
	stat_t  stat;

	// result registers
	logic              done_q;
	logic [ZONE_W-1:0] zone_code_q;
	logic              matched_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			fb_q  <= FALLBACK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_COUNT_FIRST:  cnt_q[0] <= cfg_data;
				REG_COUNT_SECOND: cnt_q[1] <= cfg_data;
				REG_COUNT_THIRD:  cnt_q[2] <= cfg_data;
				REG_FALLBACK:     fb_q     <= cfg_data[ZONE_W-1:0];
				default: ;
			endcase
		end
	end

	// out-of-range fallback reports the last zone
	assign fb_eff = (fb_q >= ZONE_W'(ZONE_COUNT)) ? ZONE_W'(ZONE_COUNT - 1) : fb_q;

	// fetch the control word for the current step
	assign uc     = ucode_rom(upc_q);
	assign busy   = !uc.accept;
	assign accept = start && !busy;

	always_comb begin
		case (uc.cond)
			C_ALWAYS:    take = 1'b1;
			C_QSTART:    take = start && (operation == OP_QUERY);
			C_SHORT:     take = stat.short_poly;
			C_EDGE_LAST: take = stat.edge_last;
			C_INSIDE:    take = stat.in_poly;
			C_LAST_ZONE: take = stat.last_zone;
			default:     take = 1'b1;
		endcase
	end

	assign upc_d = take ? uc.tgt_t : uc.tgt_f;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q  <= U_IDLE;
			done_q <= 1'b0;
		end else begin
			upc_q  <= upc_d;
			done_q <= uc.emit_hit || uc.emit_miss;
		end
	end

	// result payload, held between transactions
	always_ff @(posedge clk) begin
		if (uc.emit_hit) begin
			zone_code_q <= stat.zone;
			matched_q   <= 1'b1;
		end else if (uc.emit_miss) begin
			zone_code_q <= fb_eff;
			matched_q   <= 1'b0;
		end
	end

	assign done      = done_q;
	assign zone_code = zone_code_q;
	assign matched   = matched_q;

	// writes to a zone beyond the table are dropped
	always_comb begin
		ctl            = '0;
		ctl.wr_en      = accept && (operation == OP_WRITE) && (zone_select < ZONE_W'(ZONE_COUNT));
		ctl.ld_point   = accept && (operation == OP_QUERY);
		ctl.zone_setup = uc.zone_setup;
		ctl.ld_prev    = uc.ld_prev;
		ctl.mul1       = uc.mul1;
		ctl.mul2       = uc.mul2;
		ctl.test       = uc.test;
		ctl.zone_inc   = uc.zone_inc;
		ctl.rd_sel     = uc.rd_sel;
	end

	ppzc_datapath #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.wr_zone (zone_select),
		.wr_slot (vertex_slot),
		.in_x    (coord_x),
		.in_y    (coord_y),
		.counts  (cnt_q),
		.stat    (stat)
	);

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(upc_q == U_HIT || upc_q == U_MISS))
		else $error("result strobe without a finishing step");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two result strobes back to back");

	a_query_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (operation == OP_QUERY)) |=> (upc_q == U_ZINIT))
		else $error("accepted query did not start the zone scan");

	a_match_zone: assert property (@(posedge clk) disable iff (!arst_n)
		(done && matched) |-> (zone_code < ZONE_W'(ZONE_COUNT)))
		else $error("matched result names a zone out of range");

endmodule

### tb/sv/zone_result_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// zone_result_checker - predicts and checks zone lookups
// Mirrors vertex tables and registers, predicts each query and compares.
// ---------------------------------------------------------------------------
module zone_result_checker #(
	parameter int COORD_W = 20
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic                                 busy,
	input  logic                                 operation,
	input  logic [ppzc_pkg::ZONE_W-1:0]          zone_select,
	input  logic [ppzc_pkg::SLOT_W-1:0]          vertex_slot,
	input  logic signed [COORD_W-1:0]            coord_x,
	input  logic signed [COORD_W-1:0]            coord_y,
	input  logic                                 done,
	input  logic [ppzc_pkg::ZONE_W-1:0]          zone_code,
	input  logic                                 matched,
	input  logic                                 cfg_valid,
	input  logic                                 cfg_ready,
	input  logic [ppzc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ppzc_pkg::CFG_DATA_W-1:0]      cfg_data,
	output int                                   errors,
	output int                                   pending
);
	import ppzc_pkg::*;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic [ZONE_W-1:0] zone;
		logic              hit;
	} zone_verdict_t;

	coord_t            corner_x [STORE_DEPTH];
	coord_t            corner_y [STORE_DEPTH];
	logic [CNT_W-1:0]  zone_verts [ZONE_COUNT];
	logic [ZONE_W-1:0] fallback;
	zone_verdict_t     expected_verdicts [$];

	initial begin
		errors  = 0;
		pending = 0;
	end

	task automatic report_mismatch(input string what);
		$display("[%0t] zone check: %s", $time, what);
		errors++;
	endtask

	// even-odd crossing count, edge test done as an exact cross-multiplication
	function automatic bit point_in_zone(input int z, input longint px, input longint py);
		int     n;
		int     i;
		int     j;
		bit     odd;
		longint xi, yi, xj, yj, dy, lhs, rhs;
		n = (zone_verts[z] > MAX_VERTICES) ? MAX_VERTICES : int'(zone_verts[z]);
		if (n < MIN_POLY_VERTS)
			return 1'b0;
		odd = 1'b0;
		j   = n - 1;
		for (i = 0; i < n; i++) begin
			xi = corner_x[z * MAX_VERTICES + i];
			yi = corner_y[z * MAX_VERTICES + i];
			xj = corner_x[z * MAX_VERTICES + j];
			yj = corner_y[z * MAX_VERTICES + j];
			if ((yi > py) != (yj > py)) begin
				dy  = yj - yi;
				lhs = (px - xi) * dy;
				rhs = (xj - xi) * (py - yi);
				if ((dy > 0) ? (lhs < rhs) : (rhs < lhs))
					odd = !odd;
			end
			j = i;
		end
		return odd;
	endfunction

	function automatic zone_verdict_t classify_point(input longint px, input longint py);
		zone_verdict_t v;
		int            z;
		for (z = 0; z < ZONE_COUNT; z++) begin
			if (point_in_zone(z, px, py)) begin
				v.zone = ZONE_W'(z);
				v.hit  = 1'b1;
				return v;
			end
		end
		v.zone = (fallback >= ZONE_COUNT) ? ZONE_W'(ZONE_COUNT - 1) : fallback;
		v.hit  = 1'b0;
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		zone_verdict_t want;
		if (!arst_n) begin
			for (int k = 0; k < ZONE_COUNT; k++)
				zone_verts[k] = '0;
			fallback = FALLBACK_RESET;
			expected_verdicts.delete();
			pending = 0;
		end else begin
			if (done) begin
				if (expected_verdicts.size() == 0) begin
					report_mismatch($sformatf("unexpected result zone=%0d matched=%0b",
						zone_code, matched));
				end else begin
					want = expected_verdicts.pop_front();
					if (zone_code !== want.zone)
						report_mismatch($sformatf("zone_code %0d, expected %0d",
							zone_code, want.zone));
					if (matched !== want.hit)
						report_mismatch($sformatf("matched %0b, expected %0b",
							matched, want.hit));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_COUNT_FIRST:  zone_verts[0] = cfg_data;
					REG_COUNT_SECOND: zone_verts[1] = cfg_data;
					REG_COUNT_THIRD:  zone_verts[2] = cfg_data;
					REG_FALLBACK:     fallback      = cfg_data[ZONE_W-1:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				if (operation == OP_WRITE) begin
					if (zone_select < ZONE_COUNT && vertex_slot < MAX_VERTICES) begin
						corner_x[zone_select * MAX_VERTICES + vertex_slot] = coord_x;
						corner_y[zone_select * MAX_VERTICES + vertex_slot] = coord_y;
					end
				end else begin
					expected_verdicts.insert(expected_verdicts.size(),
						classify_point(coord_x, coord_y));
				end
			end
			pending = expected_verdicts.size();
		end
	end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top - stimulus and verdict for the polygon zone classifier
// Builds vertex tables, sweeps register settings and fires point queries;
// the checker beside the block predicts and compares every zone result.
// ---------------------------------------------------------------------------
module tb_top;
	import ppzc_pkg::*;

	localparam int COORD_W        = 20;
	localparam int RANDOM_ITEMS   = 800;
	// quiet stretches, a full query scan included, stay well below this limit
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 200;

	typedef logic signed [COORD_W-1:0] coord_t;

	localparam coord_t COORD_MAX = {1'b0, {(COORD_W - 1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_W - 1){1'b0}}};

	// coordinate spread of one phase: the tight window gives many shared
	// y values, horizontal edges and points that sit on vertices or edges
	typedef enum int {
		GEO_FULL,
		GEO_TIGHT,
		GEO_MID
	} geom_t;

	logic                  clk;
	logic                  arst_n      = 1'b0;
	logic                  start       = 1'b0;
	logic                  busy;
	logic                  operation   = OP_WRITE;
	logic [ZONE_W-1:0]     zone_select = '0;
	logic [SLOT_W-1:0]     vertex_slot = '0;
	coord_t                coord_x     = '0;
	coord_t                coord_y     = '0;
	logic                  done;
	logic [ZONE_W-1:0]     zone_code;
	logic                  matched;
	logic                  cfg_valid   = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;

	int errors;
	int pending;

	// slots written so far; a count never reaches past the written prefix,
	// so no query ever uses a vertex that was never stored
	bit     vtx_written [ZONE_COUNT][MAX_VERTICES];
	coord_t last_x = '0;
	coord_t last_y = '0;
	int     items = 0;
	int     burst_left = 0;
	bit     no_idle = 1'b0;
	int     quiet_cycles = 0;

	priority_polygon_zone_classifier #(
		.COORD_WIDTH(COORD_W)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.zone_select(zone_select),
		.vertex_slot(vertex_slot),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.done       (done),
		.zone_code  (zone_code),
		.matched    (matched),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	zone_result_checker #(
		.COORD_W(COORD_W)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.zone_select(zone_select),
		.vertex_slot(vertex_slot),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.done       (done),
		.zone_code  (zone_code),
		.matched    (matched),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.errors     (errors),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: any command, result or register transaction counts as progress
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// sender idling: bursts of back-to-back commands, then a gap; start is
	// dropped here and by settle, never in the same step that raises it again
	task automatic pace();
		if (no_idle)
			return;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		start <= 1'b0;
		repeat ($urandom_range(1, 15)) @(posedge clk);
		burst_left = $urandom_range(0, 11);
	endtask

	// one command transaction; holds start until the block takes it
	task automatic send_cmd(input logic op, input logic [ZONE_W-1:0] zsel,
			input logic [SLOT_W-1:0] slot, input coord_t x, input coord_t y);
		start       <= 1'b1;
		operation   <= op;
		zone_select <= zsel;
		vertex_slot <= slot;
		coord_x     <= x;
		coord_y     <= y;
		do @(posedge clk); while (busy);
		if (op == OP_WRITE) begin
			if (zsel < ZONE_COUNT)
				vtx_written[zsel][slot] = 1'b1;
			last_x = x;
			last_y = y;
		end
		items++;
		pace();
	endtask

	// zone and slot bits are don't-care on a query, so they toggle freely
	task automatic query(input coord_t x, input coord_t y);
		send_cmd(OP_QUERY, ZONE_W'($urandom), SLOT_W'($urandom), x, y);
	endtask

	// wait for every outstanding result, then give a trailing write time to land
	task automatic settle();
		start <= 1'b0;
		do @(negedge clk); while (pending != 0 || busy);
		repeat (4) @(posedge clk);
	endtask

	// leaves cfg_valid high so back-to-back register writes never glitch it
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic configure(input logic [CNT_W-1:0] n0, input logic [CNT_W-1:0] n1,
			input logic [CNT_W-1:0] n2, input logic [ZONE_W-1:0] fb);
		logic [CFG_DATA_W-1:0] fb_word;
		settle();
		// upper data bits of the fallback write are junk the block must drop
		fb_word              = CFG_DATA_W'($urandom);
		fb_word[ZONE_W-1:0]  = fb;
		cfg_write(REG_COUNT_FIRST, n0);
		cfg_write(REG_COUNT_SECOND, n1);
		cfg_write(REG_COUNT_THIRD, n2);
		cfg_write(REG_FALLBACK, fb_word);
		cfg_valid <= 1'b0;
	endtask

	function automatic coord_t rand_coord(input geom_t geo);
		coord_t c;
		case (geo)
			GEO_FULL:  c = coord_t'($urandom);
			GEO_TIGHT: c = coord_t'($urandom_range(0, 64) - 32);
			default:   c = coord_t'($urandom_range(0, 8192) - 4096);
		endcase
		if ($urandom_range(0, 15) == 0)
			c = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
		return c;
	endfunction

	// vertex count for a zone, bounded by its written prefix; a fully
	// written zone may also get counts above the table size (clamped)
	function automatic logic [CNT_W-1:0] pick_count(input int z);
		int w;
		w = 0;
		while (w < MAX_VERTICES && vtx_written[z][w])
			w++;
		if (w == MAX_VERTICES) begin
			case ($urandom_range(0, 5))
				0:       return CNT_W'(MAX_VERTICES);
				1:       return '1;
				default: return CNT_W'($urandom_range(0, (1 << CNT_W) - 1));
			endcase
		end
		if (w >= MIN_POLY_VERTS && $urandom_range(0, 3) != 0)
			return CNT_W'($urandom_range(MIN_POLY_VERTS, w));
		return CNT_W'($urandom_range(0, w));
	endfunction

	// one register setting followed by a mix of queries and table edits
	task automatic run_phase();
		geom_t geo;
		int    steps;
		int    r;
		int    z;
		int    k;
		int    s;
		geo     = geom_t'($urandom_range(0, 2));
		no_idle = ($urandom_range(0, 3) == 0);
		configure(pick_count(0), pick_count(1), pick_count(2), ZONE_W'($urandom_range(0, 3)));
		steps = $urandom_range(20, 50);
		repeat (steps) begin
			r = $urandom_range(0, 99);
			if (r < 65) begin
				query(rand_coord(geo), rand_coord(geo));
			end else if (r < 75) begin
				// exactly on the last vertex sent, whether it was stored or dropped
				query(last_x, last_y);
			end else if (r < 82) begin
				// rebuild a polygon from slot 0 upward
				z = $urandom_range(0, ZONE_COUNT - 1);
				k = $urandom_range(MIN_POLY_VERTS, MAX_VERTICES);
				for (s = 0; s < k; s++)
					send_cmd(OP_WRITE, ZONE_W'(z), SLOT_W'(s), rand_coord(geo), rand_coord(geo));
			end else begin
				// single edit, zone 3 included (must be dropped)
				send_cmd(OP_WRITE, ZONE_W'($urandom_range(0, 3)), SLOT_W'($urandom_range(0, 15)),
					rand_coord(geo), rand_coord(geo));
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part ---
		// reset counts are zero: every query falls back to zone 1
		query(COORD_MAX, COORD_MAX);
		query(COORD_MIN, COORD_MIN);

		// full-range triangle in zone 0, widest products of the edge test
		send_cmd(OP_WRITE, 2'd0, 4'd0, COORD_MIN, COORD_MIN);
		send_cmd(OP_WRITE, 2'd0, 4'd1, COORD_MAX, COORD_MIN);
		send_cmd(OP_WRITE, 2'd0, 4'd2, '0, COORD_MAX);
		// zone beyond the table: dropped
		send_cmd(OP_WRITE, 2'd3, 4'd15, COORD_MAX, COORD_MAX);

		// fallback out of range is reported as the last zone
		configure(5'd3, 5'd0, 5'd0, 2'd3);
		query('0, '0);
		query(COORD_MAX, COORD_MAX);
		query(COORD_MIN, COORD_MIN);
		query('0, COORD_MAX);

		// square in zone 1 with a triangle inside it in zone 2
		send_cmd(OP_WRITE, 2'd1, 4'd0, -20'sd16, -20'sd16);
		send_cmd(OP_WRITE, 2'd1, 4'd1, 20'sd16, -20'sd16);
		send_cmd(OP_WRITE, 2'd1, 4'd2, 20'sd16, 20'sd16);
		send_cmd(OP_WRITE, 2'd1, 4'd3, -20'sd16, 20'sd16);
		send_cmd(OP_WRITE, 2'd2, 4'd0, -20'sd8, '0);
		send_cmd(OP_WRITE, 2'd2, 4'd1, 20'sd8, '0);
		send_cmd(OP_WRITE, 2'd2, 4'd2, '0, 20'sd8);

		// zone 0 too short to match; zone 1 wins over zone 2 by priority
		configure(5'd2, 5'd4, 5'd3, 2'd0);
		query('0, 20'sd4);
		query(-20'sd16, '0);
		query('0, -20'sd16);
		query(20'sd100, 20'sd100);

		// zone 2 alone: inside, and on its horizontal bottom edge
		configure(5'd0, 5'd0, 5'd3, 2'd2);
		query('0, 20'sd4);
		query('0, '0);

		// --- random part ---
		items = 0;
		while (items < RANDOM_ITEMS)
			run_phase();

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		if (errors == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
